### rtl/ftts_pkg.sv
// shared types and constants for the table-directory tag search block
`timescale 1ns / 1ps

package ftts_pkg;

  localparam int MAX_TABLES_DEF = 64;

  localparam int TAG_W   = 32;
  localparam int SLOT_W  = 6;
  localparam int CFG_W   = 7;
  localparam int STEPS_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_SPAN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_STEPS = 2'd2;

  typedef struct packed {
    logic              command;
    logic [SLOT_W-1:0] entry_index;
    logic [TAG_W-1:0]  tag;
  } ftts_in_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] match_index;
  } ftts_out_t;

  // broadcast from the controller to every cell of the row
  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
    logic [TAG_W-1:0]  wr_tag;
    logic [TAG_W-1:0]  key;
    logic [CFG_W-1:0]  scan_lo;
    logic [CFG_W-1:0]  scan_hi;
  } ftts_cell_ctl_t;

endpackage

### rtl/ftts_cell.sv
// one directory slot: tag storage, key compare and one stage of the scan chain
`timescale 1ns / 1ps

module ftts_cell #(
  parameter int IDX_W = 6,
  parameter int IDX   = 0
) (
  input  logic                    clk,
  input  ftts_pkg::ftts_cell_ctl_t ctl,
  input  logic                    nb_hit,
  input  logic [IDX_W-1:0]        nb_idx,
  output logic                    lt_o,
  output logic                    eq_o,
  output logic                    hit_o,
  output logic [IDX_W-1:0]        idx_o
);

  localparam int CMP_W = (IDX_W > ftts_pkg::CFG_W) ? IDX_W : ftts_pkg::CFG_W;

  logic [ftts_pkg::TAG_W-1:0] tag_r, tag_nxt;
  logic                       lt_r, lt_nxt;
  logic                       eq_r, eq_nxt;
  logic                       hit_r, hit_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic                       my_slot;
  logic                       in_range;

  assign my_slot  = (32'(ctl.wr_slot) == IDX);
  assign in_range = (CMP_W'(IDX) >= CMP_W'(ctl.scan_lo)) &&
                    (CMP_W'(IDX) <  CMP_W'(ctl.scan_hi));

  always_comb begin
    tag_nxt = (ctl.wr_en && my_slot) ? ctl.wr_tag : tag_r;
    lt_nxt  = (ctl.key < tag_r);
    eq_nxt  = (ctl.key == tag_r);
    // a hit in this slot overrides whatever arrives from the higher slots
    if (eq_r && in_range) begin
      hit_nxt = 1'b1;
      idx_nxt = IDX_W'(IDX);
    end else begin
      hit_nxt = nb_hit;
      idx_nxt = nb_idx;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
    lt_r  <= lt_nxt;
    eq_r  <= eq_nxt;
    hit_r <= hit_nxt;
    idx_r <= idx_nxt;
  end

  assign lt_o  = lt_r;
  assign eq_o  = eq_r;
  assign hit_o = hit_r;
  assign idx_o = idx_r;

endmodule

### rtl/font_table_tag_search.sv
// top level: config registers, probe sequencer and the row of directory cells
//
//  port group   direction  handshake            contents
//  in_*         input      in_valid/in_ready    command, entry_index, tag
//  out_*        output     out_valid/out_ready  found, match_index
//  cfg_*        input      cfg_we               table_count, search_span, search_steps
//
// a load goes from acceptance to the done state and from there into the output register
// a lookup that hits during the binary probes goes through setup and the search state to done
// a lookup that goes on to the linear tail waits in the scan state until the scan chain has settled;
// the chain moves the lowest hit one cell toward slot 0 per cycle
// one transaction is in work at a time; the output register lets the next
// transaction in while a result waits; reset clears control state only
`timescale 1ns / 1ps

module font_table_tag_search #(
  parameter int MAX_TABLES = ftts_pkg::MAX_TABLES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  ftts_pkg::ftts_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ftts_pkg::ftts_out_t              out_data,
  input  logic                             cfg_we,
  input  logic [ftts_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [ftts_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int IDX_W = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
  localparam int CNT_W = $clog2(MAX_TABLES + 1);
  localparam int CFG_W = ftts_pkg::CFG_W;
  localparam int PRB_W = ftts_pkg::STEPS_W + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SETUP  = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [CFG_W-1:0]             count_r, count_nxt;
  logic [CFG_W-1:0]             span_r, span_nxt;
  logic [ftts_pkg::STEPS_W-1:0] steps_r, steps_nxt;

  logic [2:0]                   state_r, state_nxt;
  logic [ftts_pkg::TAG_W-1:0]   key_r, key_nxt;
  logic [CFG_W-1:0]             lo_r, lo_nxt;
  logic [CFG_W-1:0]             hi_r, hi_nxt;
  logic [PRB_W-1:0]             probes_r, probes_nxt;
  logic [CNT_W-1:0]             scan_cnt_r, scan_cnt_nxt;
  ftts_pkg::ftts_out_t          res_r, res_nxt;
  logic                         out_valid_r, out_valid_nxt;
  ftts_pkg::ftts_out_t          out_data_r, out_data_nxt;

  logic                         in_fire;
  logic [CFG_W-1:0]             count_c;
  logic [CFG_W-1:0]             prefix;
  logic [CFG_W-1:0]             mid;
  logic [IDX_W-1:0]             mid_idx;
  logic                         out_free;

  ftts_pkg::ftts_cell_ctl_t     cell_ctl;
  logic [MAX_TABLES-1:0]        lt_vec;
  logic [MAX_TABLES-1:0]        eq_vec;
  logic [MAX_TABLES:0]          chain_hit;
  logic [IDX_W-1:0]             chain_idx [0:MAX_TABLES];

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // entry count is capped at the size of the row; the searched prefix at the count
  assign count_c = (32'(count_r) > MAX_TABLES) ? CFG_W'(MAX_TABLES) : count_r;
  assign prefix  = (span_r > count_c) ? count_c : span_r;
  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign mid_idx = IDX_W'(mid);

  always_comb begin
    cell_ctl.wr_en   = in_fire && (in_data.command == ftts_pkg::CMD_LOAD);
    cell_ctl.wr_slot = in_data.entry_index;
    cell_ctl.wr_tag  = in_data.tag;
    cell_ctl.key     = key_r;
    cell_ctl.scan_lo = span_r;
    cell_ctl.scan_hi = count_r;
  end

  assign chain_hit[MAX_TABLES] = 1'b0;
  assign chain_idx[MAX_TABLES] = '0;

  for (genvar g = 0; g < MAX_TABLES; g++) begin : g_cell
    ftts_cell #(
      .IDX_W (IDX_W),
      .IDX   (g)
    ) u_cell (
      .clk    (clk),
      .ctl    (cell_ctl),
      .nb_hit (chain_hit[g+1]),
      .nb_idx (chain_idx[g+1]),
      .lt_o   (lt_vec[g]),
      .eq_o   (eq_vec[g]),
      .hit_o  (chain_hit[g]),
      .idx_o  (chain_idx[g])
    );
  end

  // configuration writes
  always_comb begin
    count_nxt = count_r;
    span_nxt  = span_r;
    steps_nxt = steps_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        ftts_pkg::REG_TABLE_COUNT:  count_nxt = cfg_wdata;
        ftts_pkg::REG_SEARCH_SPAN:  span_nxt  = cfg_wdata;
        ftts_pkg::REG_SEARCH_STEPS: steps_nxt = cfg_wdata[ftts_pkg::STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    key_nxt      = key_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    probes_nxt   = probes_r;
    scan_cnt_nxt = scan_cnt_r;
    res_nxt      = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          key_nxt = in_data.tag;
          if (in_data.command == ftts_pkg::CMD_LOAD) begin
            res_nxt.found       = 1'b0;
            res_nxt.match_index = '0;
            state_nxt           = S_DONE;
          end else begin
            state_nxt = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        // cells register their compare flags against the new key
        lo_nxt       = '0;
        hi_nxt       = prefix;
        probes_nxt   = '0;
        scan_cnt_nxt = '0;
        state_nxt    = S_SEARCH;
      end
      S_SEARCH: begin
        if (scan_cnt_r != CNT_W'(MAX_TABLES)) begin
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
        if ((probes_r > PRB_W'(steps_r)) || (lo_r >= hi_r)) begin
          state_nxt = S_SCAN;
        end else if (eq_vec[mid_idx]) begin
          res_nxt.found       = 1'b1;
          res_nxt.match_index = ftts_pkg::SLOT_W'(mid);
          state_nxt           = S_DONE;
        end else begin
          if (lt_vec[mid_idx]) begin
            hi_nxt = mid;
          end else begin
            lo_nxt = mid + 1'b1;
          end
          probes_nxt = probes_r + 1'b1;
        end
      end
      S_SCAN: begin
        // wait until the chain has carried every slot down to slot 0
        if (scan_cnt_r != CNT_W'(MAX_TABLES)) begin
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end else begin
          res_nxt.found       = chain_hit[0];
          res_nxt.match_index = chain_hit[0] ? ftts_pkg::SLOT_W'(chain_idx[0]) : '0;
          state_nxt           = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (state_r == S_DONE && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      span_r      <= CFG_W'(1);
      steps_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      span_r      <= span_nxt;
      steps_r     <= steps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    probes_r   <= probes_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_miss_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.found) |-> (out_data_r.match_index == '0))
    else $error("miss result carries a nonzero index");

  a_hit_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.found) |-> (32'(out_data_r.match_index) < 32'(count_r)))
    else $error("hit index not below the entry count");

  a_probe_budget: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> (probes_r <= PRB_W'(steps_r) + 1'b1))
    else $error("binary search ran past its probe budget");

  a_scan_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && state_nxt == S_DONE) |-> (scan_cnt_r == CNT_W'(MAX_TABLES)))
    else $error("scan result taken before the chain settled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("accepted transaction dropped");
`endif

endmodule

### sim/font_table_tag_search_tb.sv
// testbench for the table-directory tag search block: scoreboard with predictor, random traffic
`timescale 1ns / 1ps

module font_table_tag_search_tb;
  import ftts_pkg::*;

  localparam int NUM_SLOTS     = MAX_TABLES_DEF;
  localparam int ITEM_TARGET   = 1400;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 80;
  localparam int MAX_PRINTED   = 100;

  class tag_search_scoreboard;
    logic [TAG_W-1:0] dir_tags[NUM_SLOTS];
    int unsigned n_tables;
    int unsigned span;
    int unsigned steps;
    ftts_out_t   result_q[$];
    int          errors;

    function new();
      n_tables = 0;
      span = 1;
      steps = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_TABLE_COUNT:  n_tables = val;
        REG_SEARCH_SPAN:  span = val;
        REG_SEARCH_STEPS: steps = val[STEPS_W-1:0];
        default: ;
      endcase
    endfunction

    // binary probes over the sorted prefix, then a linear pass over the tail
    function ftts_out_t search_dir(logic [TAG_W-1:0] key);
      ftts_out_t   res;
      int unsigned count, prefix, lo, hi, mid, probe, i;
      res = '0;
      count = (n_tables > NUM_SLOTS) ? NUM_SLOTS : n_tables;
      prefix = (span > count) ? count : span;
      lo = 0;
      hi = prefix;
      for (probe = 0; probe <= steps && lo < hi; probe++) begin
        mid = lo + ((hi - lo) >> 1);
        if (key < dir_tags[mid]) begin
          hi = mid;
        end else if (key > dir_tags[mid]) begin
          lo = mid + 1;
        end else begin
          res.found = 1'b1;
          res.match_index = SLOT_W'(mid);
          return res;
        end
      end
      for (i = span; i < count; i++) begin
        if (dir_tags[i] == key) begin
          res.found = 1'b1;
          res.match_index = SLOT_W'(i);
          return res;
        end
      end
      return res;
    endfunction

    function void note_input(ftts_in_t item);
      if (item.command == CMD_LOAD) begin
        dir_tags[item.entry_index] = item.tag;
        result_q.push_back('0);
      end else begin
        result_q.push_back(search_dir(item.tag));
      end
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check_result(ftts_out_t got);
      ftts_out_t exp;
      if (result_q.size() == 0) begin
        report($sformatf("result found=%0d index=%0d with no transaction pending",
                         got.found, got.match_index));
      end else begin
        exp = result_q.pop_front();
        if (got.found !== exp.found)
          report($sformatf("found %0d, expected %0d", got.found, exp.found));
        if (got.match_index !== exp.match_index)
          report($sformatf("match_index %0d, expected %0d", got.match_index,
                           exp.match_index));
      end
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  ftts_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  ftts_out_t out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  tag_search_scoreboard sb = new();

  logic [TAG_W-1:0] cur_tags[NUM_SLOTS];
  int tx_max = 14;
  int rx_max = 14;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit hold_req = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  font_table_tag_search uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_idx, cfg_wdata);
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if (cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("font_table_tag_search test failed");
      $finish;
    end
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    int wait_cycles;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      wait_cycles = $urandom_range(0, rx_max);
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_item(logic cmd, logic [SLOT_W-1:0] slot, logic [TAG_W-1:0] key);
    int gap;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{command: cmd, entry_index: slot, tag: key};
    do @(posedge clk); while (!(in_valid && in_ready));
    items_sent++;
    if (cmd == CMD_LOAD) cur_tags[slot] = key;
  endtask

  task automatic load_tag(int slot, logic [TAG_W-1:0] key);
    send_item(CMD_LOAD, SLOT_W'(slot), key);
  endtask

  // entry_index is ignored by a lookup but still gets random bits
  task automatic lookup_tag(logic [TAG_W-1:0] key);
    send_item(CMD_LOOKUP, SLOT_W'($urandom_range(0, NUM_SLOTS - 1)), key);
  endtask

  // wait on the clock first so the scoreboard has noted a transaction accepted at this edge
  task automatic drain(int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_config(int count, int span, int steps);
    drain(4);
    cfg_we <= 1'b1;
    cfg_idx <= REG_TABLE_COUNT;
    cfg_wdata <= CFG_W'(count);
    @(posedge clk);
    cfg_idx <= REG_SEARCH_SPAN;
    cfg_wdata <= CFG_W'(span);
    @(posedge clk);
    cfg_idx <= REG_SEARCH_STEPS;
    cfg_wdata <= CFG_W'(steps);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // loads every slot with ascending tags; a narrow range gives duplicates
  task automatic fill_sorted(bit pin_ends, bit narrow);
    logic [TAG_W-1:0] vals[$];
    for (int i = 0; i < NUM_SLOTS; i++)
      vals.push_back(narrow ? TAG_W'($urandom_range(0, 40)) : TAG_W'($urandom));
    vals.sort();
    if (pin_ends) begin
      vals[0] = '0;
      vals[NUM_SLOTS-1] = '1;
    end
    for (int i = 0; i < NUM_SLOTS; i++) load_tag(i, vals[i]);
  endtask

  task automatic random_item();
    int r, slot;
    r = $urandom_range(0, 99);
    slot = $urandom_range(0, NUM_SLOTS - 1);
    if (r < 12) begin
      load_tag(slot, $urandom);
    end else if (r < 65) begin
      lookup_tag(cur_tags[slot]);
    end else if (r < 80) begin
      lookup_tag(cur_tags[slot] + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF));
    end else begin
      lookup_tag($urandom);
    end
  endtask

  task automatic random_phase(int phase);
    int sel, count, span, steps;
    sel = $urandom_range(0, 9);
    if (sel == 0) count = 0;
    else if (sel == 1) count = NUM_SLOTS;
    else if (sel == 2) count = $urandom_range(NUM_SLOTS + 1, 127);
    else count = $urandom_range(1, NUM_SLOTS);
    span = 1;
    while (span * 2 <= count && span < NUM_SLOTS) span *= 2;
    steps = 0;
    while ((1 << steps) < span) steps++;
    if ($urandom_range(0, 4) == 0) span = $urandom_range(1, NUM_SLOTS);
    if ($urandom_range(0, 4) == 0) steps = $urandom_range(0, 7);
    set_config(count, span, steps);
    tx_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
    rx_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
    if (phase == 3) begin
      // sender keeps pushing while the result side is held off
      tx_max = 0;
      hold_req = 1'b1;
    end
    if ($urandom_range(0, 1)) fill_sorted(1'b0, $urandom_range(0, 5) == 0);
    repeat ($urandom_range(40, 120)) random_item();
  endtask

  initial begin
    int phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every slot is written before the first lookup
    set_config(NUM_SLOTS, NUM_SLOTS, 6);
    fill_sorted(1'b1, 1'b0);

    lookup_tag(cur_tags[0]);
    lookup_tag(cur_tags[NUM_SLOTS-1]);
    lookup_tag(cur_tags[31]);
    lookup_tag(cur_tags[17]);
    lookup_tag(cur_tags[40] + 32'd1);

    // tail scan past a 32-entry prefix, and a tag beyond the count
    set_config(40, 32, 5);
    lookup_tag(cur_tags[35]);
    lookup_tag(cur_tags[39]);
    lookup_tag(cur_tags[40]);
    lookup_tag(cur_tags[0]);

    // count above the store size gets clamped
    set_config(127, 32, 5);
    lookup_tag(cur_tags[NUM_SLOTS-1]);
    lookup_tag(cur_tags[50]);

    // single probe budget
    set_config(NUM_SLOTS, NUM_SLOTS, 0);
    lookup_tag(cur_tags[32]);
    lookup_tag(cur_tags[0]);

    // empty directory
    set_config(0, 1, 0);
    lookup_tag(cur_tags[0]);

    // one-entry prefix, the rest by scan
    set_config(NUM_SLOTS, 1, 7);
    lookup_tag(cur_tags[0]);
    lookup_tag(cur_tags[NUM_SLOTS-1]);

    // duplicate tag out of order in the prefix
    set_config(NUM_SLOTS, NUM_SLOTS, 7);
    load_tag(5, cur_tags[60]);
    lookup_tag(cur_tags[60]);
    lookup_tag(cur_tags[4]);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      random_phase(phase);
      phase++;
    end

    drain(SETTLE_CYCLES);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("font_table_tag_search test passed");
    end else begin
      $display("font_table_tag_search test failed");
    end
    $finish;
  end

endmodule
